[sv/las_pkg.sv]
// Shared types and constants for the local alignment score block.
package las_pkg;

    localparam int SCORE_W   = 16;
    localparam int SYM_W     = 8;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [SCORE_W-1:0] SCORE_TOP = '1;

    localparam int DEF_MAX_QUERY     = 64;
    localparam int DEF_MAX_REFERENCE = 4096;

    // Request kinds carried on tuser
    localparam logic REQ_QUERY = 1'b0;
    localparam logic REQ_REF   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd2;

    localparam logic [CFG_W-1:0] MATCH_RST    = 4'd3;
    localparam logic [CFG_W-1:0] MISMATCH_RST = 4'd3;
    localparam logic [CFG_W-1:0] GAP_RST      = 4'd2;

    typedef struct packed {
        logic [CFG_W-1:0] match_score;
        logic [CFG_W-1:0] mismatch_penalty;
        logic [CFG_W-1:0] indel_cost;
    } t_cfg;

    // Control bits that travel with each reference word down the chain
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic calc;
    } t_ctl;

endpackage

[sv/las_cell.sv]
// One query cell of the systolic chain: holds one query symbol, its row score and row best.
module las_cell #(
    parameter int IDX = 0,
    parameter int QW  = 7,
    parameter int CW  = 13
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  las_pkg::t_cfg                i_cfg,
    input  logic [QW-1:0]                i_qlen,
    input  logic                         i_q_we,
    input  logic [las_pkg::SYM_W-1:0]    i_q_sym,
    input  las_pkg::t_ctl                i_ctl,
    input  logic [las_pkg::SYM_W-1:0]    i_sym,
    input  logic [CW-1:0]                i_col,
    input  logic [las_pkg::SCORE_W-1:0]  i_north,
    input  logic [las_pkg::SCORE_W-1:0]  i_diag,
    input  logic [las_pkg::SCORE_W-1:0]  i_best_score,
    input  logic [QW-1:0]                i_best_qi,
    input  logic [CW-1:0]                i_best_col,
    output las_pkg::t_ctl                o_ctl,
    output logic [las_pkg::SYM_W-1:0]    o_sym,
    output logic [CW-1:0]                o_col,
    output logic [las_pkg::SCORE_W-1:0]  o_north,
    output logic [las_pkg::SCORE_W-1:0]  o_diag,
    output logic [las_pkg::SCORE_W-1:0]  o_best_score,
    output logic [QW-1:0]                o_best_qi,
    output logic [CW-1:0]                o_best_col
);
    import las_pkg::*;

    localparam int EW = SCORE_W + 2;
    localparam logic [QW-1:0] MY_IDX = QW'(IDX);
    localparam logic [QW-1:0] MY_QI  = QW'(IDX + 1);

    logic [SYM_W-1:0]   r_qsym;
    logic [SCORE_W-1:0] r_h, n_h;
    logic [SCORE_W-1:0] r_bscore, n_bscore;
    logic [CW-1:0]      r_bcol, n_bcol;

    t_ctl               r_ctl;
    logic [SYM_W-1:0]   r_sym;
    logic [CW-1:0]      r_col;
    logic [SCORE_W-1:0] r_north, r_diag, r_bs;
    logic [QW-1:0]      r_bq;
    logic [CW-1:0]      r_bc;

    logic [SCORE_W-1:0] w_west, w_own_bs, w_h;
    logic [CW-1:0]      w_own_bc;
    logic signed [EW-1:0] w_d, w_w, w_n, w_m1, w_m2;
    logic w_active, w_comp, w_upd, w_take_own;

    always_comb begin
        w_active = MY_IDX < i_qlen;
        w_comp   = i_ctl.calc && w_active;
        // Start of a reference clears row score and row best
        w_west   = i_ctl.first ? '0 : r_h;
        w_own_bs = i_ctl.first ? '0 : r_bscore;
        w_own_bc = i_ctl.first ? '0 : r_bcol;

        if (r_qsym == i_sym) begin
            w_d = $signed({2'b00, i_diag}) + $signed(EW'(i_cfg.match_score));
        end else begin
            w_d = $signed({2'b00, i_diag}) - $signed(EW'(i_cfg.mismatch_penalty));
        end
        w_w  = $signed({2'b00, w_west}) - $signed(EW'(i_cfg.indel_cost));
        w_n  = $signed({2'b00, i_north}) - $signed(EW'(i_cfg.indel_cost));
        w_m1 = (w_d > w_w) ? w_d : w_w;
        w_m2 = (w_m1 > w_n) ? w_m1 : w_n;
        if (w_m2 < 0) begin
            w_h = '0;
        end else if (w_m2 > $signed({2'b00, SCORE_TOP})) begin
            w_h = SCORE_TOP;
        end else begin
            w_h = w_m2[SCORE_W-1:0];
        end

        n_h      = w_comp ? w_h : w_west;
        // Strict compare keeps the earliest column for this row
        w_upd    = w_comp && (w_h > w_own_bs);
        n_bscore = w_upd ? w_h : w_own_bs;
        n_bcol   = w_upd ? i_col : w_own_bc;
        // Earlier rows win ties, so the incoming best holds on equal scores
        w_take_own = n_bscore > i_best_score;
    end

    always_ff @(posedge i_clk) begin
        if (i_q_we) begin
            r_qsym <= i_q_sym;
        end
        if (i_adv && i_ctl.valid) begin
            r_h      <= n_h;
            r_bscore <= n_bscore;
            r_bcol   <= n_bcol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sym   <= i_sym;
            r_col   <= i_col;
            r_north <= n_h;
            r_diag  <= w_west;
            r_bs    <= w_take_own ? n_bscore : i_best_score;
            r_bq    <= w_take_own ? MY_QI : i_best_qi;
            r_bc    <= w_take_own ? n_bcol : i_best_col;
        end
    end

    assign o_ctl        = r_ctl;
    assign o_sym        = r_sym;
    assign o_col        = r_col;
    assign o_north      = r_north;
    assign o_diag       = r_diag;
    assign o_best_score = r_bs;
    assign o_best_qi    = r_bq;
    assign o_best_col   = r_bc;

endmodule

[sv/local_alignment_score.sv]
// Top level: query loader, reference position, systolic cell chain and result register.
//
//  channel   direction  signals                           word
//  s_*       in         i_s_tvalid o_s_tready             tuser=req_type tlast=last tdata=symbol
//  m_*       out        o_m_tvalid i_m_tready             tdata=best_score,query_end,reference_end
//  cfg_*     in         i_cfg_valid o_cfg_ready           i_cfg_index, i_cfg_data
//
// One reference word enters per cycle unless the chain stalls; a result leaves once its last
// reference word has passed the input register, the cells of the chain and the result register.
// A query word waits until the cell chain has drained, since it rewrites cell symbols.
// The chain stalls only while a result sits at its end and the output word is not taken.
// Synchronous active-low reset; no clearing pass, the first reference word clears the rows.
module local_alignment_score #(
    parameter int MAX_QUERY     = las_pkg::DEF_MAX_QUERY,
    parameter int MAX_REFERENCE = las_pkg::DEF_MAX_REFERENCE,
    parameter int QW   = $clog2(MAX_QUERY + 1),
    parameter int CW   = $clog2(MAX_REFERENCE + 1),
    parameter int TD_W = ((las_pkg::SCORE_W + QW + CW + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [las_pkg::SYM_W-1:0]      i_s_tdata,   // [7:0] symbol
    input  logic                           i_s_tuser,   // [0] req_type
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [TD_W-1:0]                o_m_tdata,   // best_score, query_end, reference_end
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [las_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [las_pkg::CFG_W-1:0]      i_cfg_data
);
    import las_pkg::*;

    localparam logic [QW-1:0] QMAX = QW'(MAX_QUERY);
    localparam logic [CW-1:0] RMAX = CW'(MAX_REFERENCE);

    t_cfg          r_cfg;
    logic          r_loading;
    logic [QW-1:0] r_qlen, n_qlen, w_qbase;
    logic [CW-1:0] r_pos, n_pos;

    t_ctl             r_in_ctl, n_in_ctl;
    logic [SYM_W-1:0] r_in_sym;
    logic [CW-1:0]    r_in_col;

    logic r_out_valid;
    logic [SCORE_W-1:0] r_out_score;
    logic [QW-1:0]      r_out_qi;
    logic [CW-1:0]      r_out_col;

    logic w_in_ref, w_acc, w_q_we, w_adv, w_chain_empty, w_first, w_calc;
    logic [MAX_QUERY-1:0] w_cell_valid;

    t_ctl               s_ctl   [0:MAX_QUERY];
    logic [SYM_W-1:0]   s_sym   [0:MAX_QUERY];
    logic [CW-1:0]      s_col   [0:MAX_QUERY];
    logic [SCORE_W-1:0] s_north [0:MAX_QUERY];
    logic [SCORE_W-1:0] s_diag  [0:MAX_QUERY];
    logic [SCORE_W-1:0] s_bs    [0:MAX_QUERY];
    logic [QW-1:0]      s_bq    [0:MAX_QUERY];
    logic [CW-1:0]      s_bc    [0:MAX_QUERY];

    // Configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.match_score      <= MATCH_RST;
            r_cfg.mismatch_penalty <= MISMATCH_RST;
            r_cfg.indel_cost       <= GAP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MATCH:    r_cfg.match_score      <= i_cfg_data;
                CFG_MISMATCH: r_cfg.mismatch_penalty <= i_cfg_data;
                CFG_GAP:      r_cfg.indel_cost       <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // Input side
    always_comb begin
        w_chain_empty = !r_in_ctl.valid && !(|w_cell_valid);
        w_adv      = !(r_out_valid && !i_m_tready && s_ctl[MAX_QUERY].valid
                       && s_ctl[MAX_QUERY].last);
        w_in_ref   = i_s_tuser == REQ_REF;
        o_s_tready = w_adv && (w_in_ref || w_chain_empty);
        w_acc      = i_s_tvalid && o_s_tready;

        // A query word after a finished query or after a reference word starts a new one
        w_qbase = r_loading ? r_qlen : '0;
        w_q_we  = w_acc && !w_in_ref && (w_qbase < QMAX);
        n_qlen  = w_q_we ? w_qbase + QW'(1) : w_qbase;

        w_first = r_pos == '0;
        w_calc  = r_pos < RMAX;
        if (i_s_tlast) begin
            n_pos = '0;
        end else if (w_calc) begin
            n_pos = r_pos + CW'(1);
        end else begin
            n_pos = r_pos;
        end

        n_in_ctl.valid = w_acc && w_in_ref;
        n_in_ctl.first = w_first;
        n_in_ctl.last  = i_s_tlast;
        n_in_ctl.calc  = w_calc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loading <= 1'b1;
            r_qlen    <= '0;
            r_pos     <= '0;
            r_in_ctl  <= '0;
        end else begin
            if (w_acc && !w_in_ref) begin
                r_qlen    <= n_qlen;
                r_loading <= !i_s_tlast;
            end
            if (w_acc && w_in_ref) begin
                r_loading <= 1'b0;
                r_pos     <= n_pos;
            end
            if (w_adv) begin
                r_in_ctl <= n_in_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_sym <= i_s_tdata;
            r_in_col <= r_pos + CW'(1);
        end
    end

    // Cell chain
    assign s_ctl[0]   = r_in_ctl;
    assign s_sym[0]   = r_in_sym;
    assign s_col[0]   = r_in_col;
    assign s_north[0] = '0;
    assign s_diag[0]  = '0;
    assign s_bs[0]    = '0;
    assign s_bq[0]    = '0;
    assign s_bc[0]    = '0;

    for (genvar g = 0; g < MAX_QUERY; g++) begin : g_cell
        logic w_we;
        assign w_we = w_q_we && (w_qbase == QW'(g));
        assign w_cell_valid[g] = s_ctl[g+1].valid;

        las_cell #(
            .IDX (g),
            .QW  (QW),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_adv        (w_adv),
            .i_cfg        (r_cfg),
            .i_qlen       (r_qlen),
            .i_q_we       (w_we),
            .i_q_sym      (i_s_tdata),
            .i_ctl        (s_ctl[g]),
            .i_sym        (s_sym[g]),
            .i_col        (s_col[g]),
            .i_north      (s_north[g]),
            .i_diag       (s_diag[g]),
            .i_best_score (s_bs[g]),
            .i_best_qi    (s_bq[g]),
            .i_best_col   (s_bc[g]),
            .o_ctl        (s_ctl[g+1]),
            .o_sym        (s_sym[g+1]),
            .o_col        (s_col[g+1]),
            .o_north      (s_north[g+1]),
            .o_diag       (s_diag[g+1]),
            .o_best_score (s_bs[g+1]),
            .o_best_qi    (s_bq[g+1]),
            .o_best_col   (s_bc[g+1])
        );
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && s_ctl[MAX_QUERY].valid && s_ctl[MAX_QUERY].last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && s_ctl[MAX_QUERY].valid && s_ctl[MAX_QUERY].last) begin
            r_out_score <= s_bs[MAX_QUERY];
            r_out_qi    <= s_bq[MAX_QUERY];
            r_out_col   <= s_bc[MAX_QUERY];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = TD_W'({r_out_col, r_out_qi, r_out_score});

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |=> r_out_valid && $stable(r_out_score)
            && $stable(r_out_qi) && $stable(r_out_col))
        else $error("result word overwritten while stalled");

    a_qlen_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_chain_empty |=> $stable(r_qlen))
        else $error("query changed with reference words in flight");

    a_pos_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_in_ref && i_s_tlast |=> r_pos == '0)
        else $error("reference position not restarted after last word");

    a_zero_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_score == '0) == (r_out_qi == '0)))
        else $error("best position disagrees with best score");
`endif

endmodule

[verif/local_alignment_score_test.sv]
// Self-checking testbench for the local alignment score block: directed and random streams.
`timescale 1ns / 1ps

module local_alignment_score_test;
    import las_pkg::*;

    localparam int QUERY_END_W = $clog2(DEF_MAX_QUERY + 1);
    localparam int REF_END_W   = $clog2(DEF_MAX_REFERENCE + 1);
    localparam int RESULT_W    = ((SCORE_W + QUERY_END_W + REF_END_W + 7) / 8) * 8;
    localparam int CHAIN_DEPTH = DEF_MAX_QUERY + 1;
    localparam int QIDX_W      = $clog2(DEF_MAX_QUERY);

    // best_score sits in the low bits, reference_end in the high ones
    typedef struct packed {
        logic [REF_END_W-1:0]   r_end;
        logic [QUERY_END_W-1:0] q_end;
        logic [SCORE_W-1:0]     score;
    } align_result_t;

    class las_scoreboard;
        int match_score;
        int mismatch_penalty;
        int indel_cost;
        logic [SYM_W-1:0] query_sym [DEF_MAX_QUERY];
        int query_len;
        int col_score [DEF_MAX_QUERY];
        int ref_pos;
        int best_score;
        int best_q;
        int best_r;
        bit loading;
        align_result_t alignments_due [$];
        int errors;

        function new();
            match_score      = MATCH_RST;
            mismatch_penalty = MISMATCH_RST;
            indel_cost       = GAP_RST;
            foreach (query_sym[i]) query_sym[i] = '0;
            foreach (col_score[i]) col_score[i] = 0;
            query_len  = 0;
            ref_pos    = 0;
            best_score = 0;
            best_q     = 0;
            best_r     = 0;
            loading    = 1'b1;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_MATCH:    match_score = int'(val);
                CFG_MISMATCH: mismatch_penalty = int'(val);
                CFG_GAP:      indel_cost = int'(val);
                default: ;
            endcase
        endfunction

        // One column of the score matrix against every loaded query symbol
        function void score_column(logic [SYM_W-1:0] sym);
            int diag;
            int north;
            int west;
            int h_val;
            diag  = 0;
            north = 0;
            for (int i = 0; i < query_len; i++) begin
                west  = col_score[QIDX_W'(i)];
                h_val = (query_sym[QIDX_W'(i)] == sym) ? diag + match_score
                                                       : diag - mismatch_penalty;
                if (west - indel_cost > h_val) h_val = west - indel_cost;
                if (north - indel_cost > h_val) h_val = north - indel_cost;
                if (h_val < 0) h_val = 0;
                if (h_val > int'(SCORE_TOP)) h_val = int'(SCORE_TOP);
                // keep the first maximum in row-major order
                if (h_val > 0 && (h_val > best_score ||
                                  (h_val == best_score && i + 1 < best_q))) begin
                    best_score = h_val;
                    best_q     = i + 1;
                    best_r     = ref_pos;
                end
                diag                   = west;
                col_score[QIDX_W'(i)] = h_val;
                north                  = h_val;
            end
        endfunction

        function void note_word(logic req, logic [SYM_W-1:0] sym, logic last);
            align_result_t res;
            if (req == REQ_QUERY) begin
                if (!loading) begin
                    query_len = 0;
                    loading   = 1'b1;
                end
                if (query_len < DEF_MAX_QUERY) begin
                    query_sym[QIDX_W'(query_len)] = sym;
                    query_len++;
                end
                if (last) loading = 1'b0;
            end else begin
                loading = 1'b0;
                if (ref_pos == 0) begin
                    foreach (col_score[i]) col_score[i] = 0;
                    best_score = 0;
                    best_q     = 0;
                    best_r     = 0;
                end
                if (ref_pos < DEF_MAX_REFERENCE) begin
                    ref_pos++;
                    score_column(sym);
                end
                if (last) begin
                    res.score = SCORE_W'(best_score);
                    res.q_end = QUERY_END_W'(best_q);
                    res.r_end = REF_END_W'(best_r);
                    alignments_due.push_back(res);
                    ref_pos = 0;
                end
            end
        endfunction

        function void compare_field(string field, logic [SCORE_W-1:0] want,
                                    logic [SCORE_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(align_result_t got);
            align_result_t want;
            if (alignments_due.size() == 0) begin
                $display("%0t: unexpected result, expected none actual score %0d q %0d r %0d",
                         $time, got.score, got.q_end, got.r_end);
                errors++;
                return;
            end
            want = alignments_due.pop_front();
            compare_field("best_score", want.score, got.score);
            compare_field("query_end", SCORE_W'(want.q_end), SCORE_W'(got.q_end));
            compare_field("reference_end", SCORE_W'(want.r_end), SCORE_W'(got.r_end));
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [SYM_W-1:0]      i_s_tdata;
    logic                  i_s_tuser;
    logic                  i_s_tlast;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [RESULT_W-1:0]   o_m_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;

    las_scoreboard board;
    int src_idle = 0;
    int snk_idle = 0;
    int hold_req = 0;
    int hold_left = 0;
    int words_sent = 0;

    local_alignment_score i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver: random back-pressure, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= snk_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            board.check_result(align_result_t'(o_m_tdata[SCORE_W+QUERY_END_W+REF_END_W-1:0]));
    end

    task automatic send_word(input logic req, input logic [SYM_W-1:0] sym, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= sym;
        i_s_tuser  <= req;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_word(req, sym, last);
        words_sent++;
    endtask

    function automatic logic [SYM_W-1:0] pick_symbol(bit full_byte);
        logic [SYM_W-1:0] bases [4] = '{8'h41, 8'h43, 8'h47, 8'h54};
        if (full_byte) return SYM_W'($urandom_range(255));
        return bases[2'($urandom_range(3))];
    endfunction

    task automatic send_query(input int len, input bit full_byte, input bit mark_last);
        for (int i = 0; i < len; i++)
            send_word(REQ_QUERY, pick_symbol(full_byte), mark_last && i == len - 1);
    endtask

    task automatic send_reference(input int len, input bit full_byte, input bit mark_last);
        for (int i = 0; i < len; i++)
            send_word(REQ_REF, pick_symbol(full_byte), mark_last && i == len - 1);
    endtask

    // Drop valid, wait for every result, then let the cell chain empty out
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (board.alignments_due.size() != 0) @(posedge i_clk);
        repeat (CHAIN_DEPTH + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_scoring(input int match_v, input int mismatch_v, input int indel_v);
        drain();
        write_reg(CFG_MATCH, CFG_W'(match_v));
        write_reg(CFG_MISMATCH, CFG_W'(mismatch_v));
        write_reg(CFG_GAP, CFG_W'(indel_v));
    endtask

    function automatic int pick_weight();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15) return 0;
        if (roll < 30) return 15;
        return $urandom_range(15);
    endfunction

    function automatic int pick_query_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 4) return $urandom_range(DEF_MAX_QUERY + 1, DEF_MAX_QUERY + 6);
        if (roll < 10) return $urandom_range(20, DEF_MAX_QUERY);
        return $urandom_range(1, 10);
    endfunction

    function automatic int pick_ref_len();
        if ($urandom_range(99) < 5) return $urandom_range(30, 80);
        return $urandom_range(1, 12);
    endfunction

    task automatic random_traffic(input int words);
        int start;
        int roll;
        bit wide;
        start = words_sent;
        while (words_sent - start < words) begin
            roll = $urandom_range(99);
            wide = ($urandom_range(99) < 25);
            if (roll < 78) begin
                send_query(pick_query_len(), wide, 1'b1);
                repeat ($urandom_range(1, 3)) send_reference(pick_ref_len(), wide, 1'b1);
            end else if (roll < 86) begin
                // reference cuts the query load short
                send_query($urandom_range(1, 8), wide, 1'b0);
                send_reference(pick_ref_len(), wide, 1'b1);
            end else if (roll < 93) begin
                // reload the query in the middle of a reference
                send_reference($urandom_range(1, 5), wide, 1'b0);
                send_query($urandom_range(1, 8), wide, 1'b1);
                send_reference(pick_ref_len(), wide, 1'b1);
            end else begin
                send_reference(1, wide, 1'b1);
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = REQ_QUERY;
        i_s_tlast   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MATCH;
        i_cfg_data  = '0;
        board = new();
        src_idle = 15;
        snk_idle = 48;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty query gives an all-zero result
        send_word(REQ_REF, 8'h00, 1'b1);
        send_word(REQ_QUERY, 8'h00, 1'b0);
        send_word(REQ_QUERY, 8'hFF, 1'b0);
        send_word(REQ_QUERY, 8'h55, 1'b0);
        send_word(REQ_QUERY, 8'hAA, 1'b1);
        send_word(REQ_REF, 8'hFF, 1'b0);
        send_word(REQ_REF, 8'h55, 1'b0);
        send_word(REQ_REF, 8'hAA, 1'b0);
        send_word(REQ_REF, 8'h00, 1'b1);
        // unterminated query, closed by the first reference word
        send_word(REQ_QUERY, 8'h41, 1'b0);
        send_word(REQ_QUERY, 8'h42, 1'b0);
        send_word(REQ_REF, 8'h41, 1'b0);
        send_word(REQ_REF, 8'h42, 1'b1);
        // equal scores in one column: keep the lower query index
        send_word(REQ_QUERY, 8'h41, 1'b0);
        send_word(REQ_QUERY, 8'h41, 1'b1);
        send_word(REQ_REF, 8'h41, 1'b0);
        send_word(REQ_REF, 8'h41, 1'b1);
        set_scoring(15, 15, 15);
        send_word(REQ_QUERY, 8'h10, 1'b0);
        send_word(REQ_QUERY, 8'h20, 1'b1);
        send_word(REQ_REF, 8'h20, 1'b0);
        send_word(REQ_REF, 8'h10, 1'b1);
        set_scoring(0, 0, 0);
        send_word(REQ_QUERY, 8'h33, 1'b1);
        send_word(REQ_REF, 8'h33, 1'b1);

        set_scoring(pick_weight(), pick_weight(), pick_weight());
        random_traffic(100);
        set_scoring(pick_weight(), pick_weight(), pick_weight());
        random_traffic(100);

        src_idle = 48;
        snk_idle = 15;
        set_scoring(pick_weight(), pick_weight(), pick_weight());
        random_traffic(100);
        set_scoring(pick_weight(), pick_weight(), pick_weight());
        random_traffic(100);

        src_idle = 0;
        snk_idle = 0;
        set_scoring(15, 0, 0);
        // hold the output long enough for results to back up into the input
        hold_req = 400;
        send_query(3, 1'b0, 1'b1);
        repeat (40) send_reference($urandom_range(1, 2), 1'b0, 1'b1);
        // overlong query, then a long reference
        send_query(DEF_MAX_QUERY + 5, 1'b0, 1'b1);
        send_reference(20, 1'b0, 1'b1);
        send_query(8, 1'b0, 1'b1);
        send_reference(40, 1'b0, 1'b1);
        set_scoring(pick_weight(), pick_weight(), pick_weight());
        random_traffic(50);

        drain();
        if (board.errors == 0 && board.alignments_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
sv/las_pkg.sv
sv/las_cell.sv
sv/local_alignment_score.sv
verif/local_alignment_score_test.sv
